// File: hw/rtl/fpu_register_stack_macros.svh
// ----------------------------------------------------------------------------
// fpu_register_stack_macros.svh
// Assertion macros used by the register stack RTL.
// ----------------------------------------------------------------------------
`ifndef FPU_REGISTER_STACK_MACROS_SVH
`define FPU_REGISTER_STACK_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define FRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("register stack assertion failed");

// Check that cons holds in the cycle after ante
`define FRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("register stack assertion failed");

`endif

// File: hw/rtl/fpu_rs_pkg.sv
// ----------------------------------------------------------------------------
// fpu_rs_pkg
// Types, codes and helpers for the x87-style register stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpu_rs_pkg;

	localparam int StackDepth = 8;
	localparam int PtrW       = $clog2(StackDepth);
	localparam int MantW      = 64;
	localparam int SexpW      = 16;
	localparam int EntryW     = MantW + SexpW;
	localparam int StatusW    = 16;
	localparam int CcW        = 4;

	// Status word layout
	localparam int StC3Bit   = 14;
	localparam int StTopLsb  = 11;
	localparam int StCcLsb   = 8;

	typedef enum logic [2:0] {
		REQ_READ      = 3'd0,
		REQ_WRITE     = 3'd1,
		REQ_PUSH      = 3'd2,
		REQ_POP       = 3'd3,
		REQ_RD_STATUS = 3'd4,
		REQ_WR_STATUS = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_EMPTY    = 2'd1,
		ERR_OCCUPIED = 2'd2
	} err_t;

	// Item details carried alongside the memory read
	typedef struct packed {
		logic               use_rdata;
		logic [StatusW-1:0] status;
		err_t               err;
	} meta_t;

	// Pack top pointer and condition code into the status word
	function automatic logic [StatusW-1:0] pack_status(input logic [PtrW-1:0] top,
			input logic [CcW-1:0] cc);
		logic [StatusW-1:0] s;
		s = '0;
		s[StC3Bit] = cc[3];
		s[StTopLsb +: PtrW] = top;
		s[StCcLsb +: 3] = cc[2:0];
		return s;
	endfunction

endpackage

// File: hw/rtl/fpu_rs_ram.sv
// ----------------------------------------------------------------------------
// fpu_rs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpu_rs_ram #(
	parameter int Width = 80,
	parameter int Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write and read; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hw/rtl/fpu_register_stack.sv
// ----------------------------------------------------------------------------
// fpu_register_stack
// Eight-entry x87-style register stack with status word and error codes.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on in_valid with in_stall low and carries a request type,
// a stack position, an 80-bit value and a status word. Each item yields
// exactly one result on the output channel (out_valid / out_stall): the
// value read or popped, the status word after the operation and an error
// code. Values live in a single-port RAM with registered read data; the
// valid bits, top pointer and condition code sit in flops and are updated
// at acceptance, so a following item sees the new state at once.
// An accepted item passes the RAM read stage, then the output register,
// before out_valid rises. Throughput: one item per cycle while the output
// is taken; the single RAM port sets this figure.
// When the receiver stalls, the output register holds, then the read stage
// holds and in_stall rises; nothing is dropped.
// Reset empties the stack: all valid bits clear, top and condition code
// zero. RAM contents are not cleared; an empty entry is never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fpu_register_stack_macros.svh"

module fpu_register_stack (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         req_type,
	input  logic [fpu_rs_pkg::PtrW-1:0]        entry_index,
	input  logic [fpu_rs_pkg::MantW-1:0]       value_mantissa,
	input  logic [fpu_rs_pkg::SexpW-1:0]       value_sign_exponent,
	input  logic [fpu_rs_pkg::StatusW-1:0]     status_word_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [fpu_rs_pkg::MantW-1:0]       read_mantissa,
	output logic [fpu_rs_pkg::SexpW-1:0]       read_sign_exponent,
	output logic [fpu_rs_pkg::StatusW-1:0]     status_word,
	output logic [1:0]                         error_code
);

	import fpu_rs_pkg::*;

	logic [StackDepth-1:0] entry_valid_q, entry_valid_d;
	logic [PtrW-1:0]       top_q, top_d;
	logic [CcW-1:0]        cc_q, cc_d;

	logic                  valid_s1;
	meta_t                 meta_s1, meta_d;

	logic                  out_valid_q;
	logic [MantW-1:0]      out_mant_q;
	logic [SexpW-1:0]      out_sexp_q;
	logic [StatusW-1:0]    out_status_q;
	logic [1:0]            out_err_q;

	logic                  in_acc, s1_advance, out_load;
	logic [PtrW-1:0]       slot;
	logic                  ram_we, ram_re;
	logic [EntryW-1:0]     ram_rdata;
	req_t                  req;

	assign req = req_t'(req_type);

	// Handshake: output register frees the read stage, which frees the input
	assign out_load   = !out_valid_q || !out_stall;
	assign s1_advance = valid_s1 && out_load;
	assign in_stall   = valid_s1 && !out_load;
	assign in_acc     = in_valid && !in_stall;

	// Decode the item and work out the next stack state
	always_comb begin
		entry_valid_d = entry_valid_q;
		top_d         = top_q;
		cc_d          = cc_q;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		meta_d.use_rdata = 1'b0;
		meta_d.err       = ERR_OK;
		slot          = top_q + entry_index;
		case (req)
			REQ_READ: begin
				if (!entry_valid_q[slot]) begin
					meta_d.err = ERR_EMPTY;
				end else begin
					ram_re = 1'b1;
					meta_d.use_rdata = 1'b1;
				end
			end
			REQ_WRITE: begin
				if (!entry_valid_q[slot]) begin
					meta_d.err = ERR_EMPTY;
				end else begin
					ram_we = 1'b1;
				end
			end
			REQ_PUSH: begin
				slot = top_q - PtrW'(1);
				if (entry_valid_q[slot]) begin
					meta_d.err = ERR_OCCUPIED;
				end else begin
					ram_we = 1'b1;
					top_d = slot;
					entry_valid_d[slot] = 1'b1;
				end
			end
			REQ_POP: begin
				slot = top_q;
				if (!entry_valid_q[slot]) begin
					meta_d.err = ERR_EMPTY;
				end else begin
					ram_re = 1'b1;
					meta_d.use_rdata = 1'b1;
					entry_valid_d[slot] = 1'b0;
					top_d = top_q + PtrW'(1);
				end
			end
			REQ_WR_STATUS: begin
				cc_d = {status_word_in[StC3Bit], status_word_in[StCcLsb +: 3]};
			end
			default: begin
			end
		endcase
		meta_d.status = pack_status(top_d, cc_d);
	end

	// Value storage
	fpu_rs_ram #(
		.Width(EntryW),
		.Depth(StackDepth)
	) u_ram (
		.clk  (clk),
		.we   (in_acc && ram_we),
		.re   (in_acc && ram_re),
		.addr (slot),
		.wdata({value_sign_exponent, value_mantissa}),
		.rdata(ram_rdata)
	);

	// Commit stack state on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			top_q         <= '0;
			cc_q          <= '0;
		end else if (in_acc) begin
			entry_valid_q <= entry_valid_d;
			top_q         <= top_d;
			cc_q          <= cc_d;
		end
	end

	// Read stage: hold the item while the RAM data comes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			meta_s1 <= meta_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			out_mant_q   <= meta_s1.use_rdata ? ram_rdata[MantW-1:0] : '0;
			out_sexp_q   <= meta_s1.use_rdata ? ram_rdata[EntryW-1:MantW] : '0;
			out_status_q <= meta_s1.status;
			out_err_q    <= meta_s1.err;
		end
	end

	assign out_valid          = out_valid_q;
	assign read_mantissa      = out_mant_q;
	assign read_sign_exponent = out_sexp_q;
	assign status_word        = out_status_q;
	assign error_code         = out_err_q;

	// Assertions
	`FRS_ASSERT_NEXT(a_push_sets_valid, clk, arst_n,
		in_acc && req == REQ_PUSH && meta_d.err == ERR_OK, entry_valid_q[top_q])
	`FRS_ASSERT_NEXT(a_held_rdata_stable, clk, arst_n,
		valid_s1 && !s1_advance, valid_s1 && $stable(ram_rdata))
	`FRS_ASSERT_NOW(a_error_reads_zero, clk, arst_n,
		out_valid_q && out_err_q != ERR_OK, out_mant_q == '0 && out_sexp_q == '0)

endmodule

// File: verif/fpu_register_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpu_register_stack_tb
// Self-checking bench for the eight-entry x87-style register stack.
// A short directed run covers empty and full stack errors, value extremes,
// every request type and the condition code bits. Four random phases then
// mostly issue well-formed push/pop/read/write traffic, with some random
// requests mixed in, under changing sender idling and receiver stalls.
// Every accepted item is predicted by a local copy of the stack, and each
// result is compared field by field in order.
// ----------------------------------------------------------------------------

module fpu_register_stack_tb;
	import fpu_rs_pkg::*;

	typedef struct {
		logic [MantW-1:0]   mant;
		logic [SexpW-1:0]   sexp;
		logic [StatusW-1:0] status;
		err_t               err;
	} stack_result_t;

	// Local copy of the stack plus the results still owed by the block
	class stack_tracker;
		logic [MantW-1:0] held_mant [StackDepth];
		logic [SexpW-1:0] held_sexp [StackDepth];
		logic             held_valid [StackDepth];
		logic [PtrW-1:0]  top;
		logic [CcW-1:0]   cc;
		stack_result_t    pending_results [$];
		int unsigned      failures;

		function new();
			for (int k = 0; k < StackDepth; k++) begin
				held_mant[k]  = '0;
				held_sexp[k]  = '0;
				held_valid[k] = 1'b0;
			end
			top      = '0;
			cc       = '0;
			failures = 0;
		endfunction

		function int unsigned depth();
			int unsigned n;
			n = 0;
			for (int k = 0; k < StackDepth; k++)
				n += held_valid[k];
			return n;
		endfunction

		// Apply one accepted item and queue the result it must produce
		function void note_item(req_t req, logic [PtrW-1:0] idx, logic [MantW-1:0] m,
				logic [SexpW-1:0] s, logic [StatusW-1:0] sw);
			logic [PtrW-1:0] slot;
			stack_result_t   r;
			r.mant = '0;
			r.sexp = '0;
			r.err  = ERR_OK;
			case (req)
				REQ_READ: begin
					slot = top + idx;
					if (!held_valid[slot]) begin
						r.err = ERR_EMPTY;
					end else begin
						r.mant = held_mant[slot];
						r.sexp = held_sexp[slot];
					end
				end
				REQ_WRITE: begin
					slot = top + idx;
					if (!held_valid[slot]) begin
						r.err = ERR_EMPTY;
					end else begin
						held_mant[slot] = m;
						held_sexp[slot] = s;
					end
				end
				REQ_PUSH: begin
					slot = top - 1'b1;
					if (held_valid[slot]) begin
						r.err = ERR_OCCUPIED;
					end else begin
						top              = slot;
						held_valid[slot] = 1'b1;
						held_mant[slot]  = m;
						held_sexp[slot]  = s;
					end
				end
				REQ_POP: begin
					slot = top;
					if (!held_valid[slot]) begin
						r.err = ERR_EMPTY;
					end else begin
						r.mant           = held_mant[slot];
						r.sexp           = held_sexp[slot];
						held_valid[slot] = 1'b0;
						top              = slot + 1'b1;
					end
				end
				REQ_WR_STATUS: cc = {sw[14], sw[10:8]};
				default: ;
			endcase
			r.status = {1'b0, cc[3], top, cc[2:0], 8'h00};
			pending_results.push_back(r);
		endfunction

		// Compare one result with the oldest outstanding prediction
		function void check_result(logic [MantW-1:0] m, logic [SexpW-1:0] s,
				logic [StatusW-1:0] st, logic [1:0] e);
			stack_result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with no item outstanding", $realtime);
				return;
			end
			want = pending_results.pop_front();
			if (want.mant !== m || want.sexp !== s || want.status !== st || want.err !== e) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch mant %h/%h sexp %h/%h status %h/%h err %0d/%0d",
						$realtime, want.mant, m, want.sexp, s, want.status, st, want.err, e);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic [PtrW-1:0]    entry_index;
	logic [MantW-1:0]   value_mantissa;
	logic [SexpW-1:0]   value_sign_exponent;
	logic [StatusW-1:0] status_word_in;
	logic               out_valid;
	logic               out_stall;
	logic [MantW-1:0]   read_mantissa;
	logic [SexpW-1:0]   read_sign_exponent;
	logic [StatusW-1:0] status_word;
	logic [1:0]         error_code;

	stack_tracker book;
	int unsigned  sender_idle_pct;
	int unsigned  recv_stall_pct;

	fpu_register_stack dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.req_type           (req_type),
		.entry_index        (entry_index),
		.value_mantissa     (value_mantissa),
		.value_sign_exponent(value_sign_exponent),
		.status_word_in     (status_word_in),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.read_mantissa      (read_mantissa),
		.read_sign_exponent (read_sign_exponent),
		.status_word        (status_word),
		.error_code         (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Stall the output at random once out of reset
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Check every result taken from the block
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result(read_mantissa, read_sign_exponent, status_word, error_code);
	end

	// Offer one item, hold it until taken, then note it. Starts and ends at a falling edge.
	task automatic send_item(req_t req, logic [PtrW-1:0] idx, logic [MantW-1:0] m,
			logic [SexpW-1:0] s, logic [StatusW-1:0] sw);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid            <= 1'b1;
		req_type            <= req;
		entry_index         <= idx;
		value_mantissa      <= m;
		value_sign_exponent <= s;
		status_word_in      <= sw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.note_item(req, idx, m, s, sw);
		@(negedge clk);
	endtask

	// Mostly legal stack traffic for the current depth, some random requests
	task automatic random_item();
		int unsigned      d;
		int unsigned      w;
		req_t             req;
		logic [PtrW-1:0]  idx;
		logic [MantW-1:0] m;
		logic [SexpW-1:0] s;
		d   = book.depth();
		w   = $urandom_range(0, 99);
		idx = PtrW'($urandom_range(0, StackDepth - 1));
		if (w < 10) begin
			req = req_t'($urandom_range(0, 5));
		end else if (w < 35 && d > 0) begin
			req = REQ_READ;
			idx = PtrW'($urandom_range(0, d - 1));
		end else if (w < 50 && d > 0) begin
			req = REQ_WRITE;
			idx = PtrW'($urandom_range(0, d - 1));
		end else if (w < 72 && d < StackDepth) begin
			req = REQ_PUSH;
		end else if (w < 92 && d > 0) begin
			req = REQ_POP;
		end else if (w[0]) begin
			req = REQ_RD_STATUS;
		end else begin
			req = REQ_WR_STATUS;
		end
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = '1;
			default: m = {$urandom, $urandom};
		endcase
		case ($urandom_range(0, 7))
			0: s = '0;
			1: s = '1;
			default: s = SexpW'($urandom_range(0, 65535));
		endcase
		send_item(req, idx, m, s, StatusW'($urandom_range(0, 65535)));
	endtask

	initial begin
		arst_n              = 1'b0;
		in_valid            = 1'b0;
		req_type            = REQ_READ;
		entry_index         = '0;
		value_mantissa      = '0;
		value_sign_exponent = '0;
		status_word_in      = '0;
		out_stall           = 1'b0;
		sender_idle_pct     = 0;
		recv_stall_pct      = 0;
		book                = new();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty stack: pop, read and write all fail
		send_item(REQ_POP, 0, '0, '0, '0);
		send_item(REQ_READ, 3, '0, '0, '0);
		send_item(REQ_WRITE, 7, '1, '1, '0);
		// Condition code set from a full status word, then read back
		send_item(REQ_WR_STATUS, 0, '0, '0, 16'hFFFF);
		send_item(REQ_RD_STATUS, 0, '0, '0, '0);
		// Fill the stack with extreme and alternating values, wrapping top
		send_item(REQ_PUSH, 0, '0, '0, '0);
		send_item(REQ_PUSH, 0, '1, '1, '0);
		send_item(REQ_PUSH, 0, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, '0);
		send_item(REQ_PUSH, 0, 64'h5555_5555_5555_5555, 16'h5555, '0);
		send_item(REQ_PUSH, 0, 64'h8000_0000_0000_0000, 16'h8000, '0);
		send_item(REQ_PUSH, 0, 64'h0000_0000_0000_0001, 16'h7FFF, '0);
		send_item(REQ_PUSH, 0, {$urandom, $urandom}, 16'h0001, '0);
		send_item(REQ_PUSH, 0, {$urandom, $urandom}, 16'hFFFE, '0);
		// Full stack: push hits an occupied entry
		send_item(REQ_PUSH, 0, '1, '1, '0);
		send_item(REQ_READ, 0, '0, '0, '0);
		send_item(REQ_READ, 7, '0, '0, '0);
		send_item(REQ_WRITE, 4, '1, '1, '0);
		send_item(REQ_READ, 4, '0, '0, '0);
		// Only bit 14 and bits 10..8 reach the condition code
		send_item(REQ_WR_STATUS, 0, '0, '0, 16'h4700);
		send_item(REQ_WR_STATUS, 0, '0, '0, 16'hB8FF);
		send_item(REQ_POP, 0, '0, '0, '0);
		send_item(REQ_POP, 0, '0, '0, '0);
		send_item(REQ_POP, 0, '0, '0, '0);

		// Random traffic under four idling patterns
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph == 1) ? 88 : (ph == 3) ? 28 : 0;
			recv_stall_pct  = (ph == 2) ? 88 : (ph == 3) ? 28 : 0;
			for (int n = 0; n < 332; n++)
				random_item();
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then allow for the pipeline latency
		while (book.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (book.failures == 0 && book.pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
